@@ src/lobm_pkg.sv @@
// Package with the shared types, codes and helper functions of the order book matcher.
`timescale 1ns / 1ps
package lobm_pkg;

   localparam int TICK_COUNT_DEF     = 1024;
   localparam int ORDER_CAPACITY_DEF = 32;
   localparam int ID_W               = 32;
   localparam int TRADER_W           = 16;
   localparam int PRICE_W            = 16;
   localparam int QTY_W              = 32;
   localparam int TICK_W             = 10;
   localparam int KEY_W              = PRICE_W + 1;
   // Wide enough for a slot number of the largest book.
   localparam int SLOT_W             = 6;

   // Operation codes of an input item.
   typedef enum logic [1:0] {
      OP_LIMIT  = 2'd0,
      OP_MARKET = 2'd1,
      OP_CANCEL = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   // Result kinds.
   typedef enum logic [2:0] {
      RK_TRADE     = 3'd0,
      RK_RESTED    = 3'd1,
      RK_DONE      = 3'd2,
      RK_REJECTED  = 3'd3,
      RK_CANCELLED = 3'd4,
      RK_NOT_FOUND = 3'd5,
      RK_FULL      = 3'd6
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_WORK
   } state_type;

   // What every cell does with its content.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_TRIM
   } cell_op_type;

   // One resting order. The slot is the lowest number free when the order rested;
   // among resting orders that share an id, a cancel takes the lowest slot.
   typedef struct packed {
      logic                valid;
      logic [ID_W-1:0]     order_id;
      logic [TRADER_W-1:0] trader;
      logic                is_sell;
      logic [PRICE_W-1:0]  price;
      logic [QTY_W-1:0]    quantity;
      logic [SLOT_W-1:0]   slot;
   } entry_type;

   // Search criteria broadcast to the row.
   typedef struct packed {
      logic                by_id;
      logic [ID_W-1:0]     order_id;
      logic                side;
      logic [TRADER_W-1:0] trader;
      logic [PRICE_W-1:0]  limit;
   } search_type;

   // Control broadcast to every cell.
   typedef struct packed {
      cell_op_type      op;
      entry_type        new_entry;
      logic [QTY_W-1:0] trim;
      search_type       search;
   } cell_ctl_type;

   // Sort key: bids first by falling price, then asks by rising price.
   function automatic logic [KEY_W-1:0] sort_key(input entry_type e);
      sort_key = {e.is_sell, e.is_sell ? e.price : ~e.price};
   endfunction

endpackage

@@ src/lobm_cell.sv @@
// One cell of the sorted order row: holds a resting order and shifts with its neighbors.
`timescale 1ns / 1ps
module lobm_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  lobm_pkg::cell_ctl_type ctl,
   input  lobm_pkg::entry_type  prev_entry,
   input  lobm_pkg::entry_type  next_entry,
   input  logic                 prev_after,
   input  logic                 prev_found,
   input  logic [lobm_pkg::SLOT_W-1:0] win_slot,
   output lobm_pkg::entry_type  entry,
   output logic                 after_out,
   output logic                 found_out,
   output logic                 eligible_out,
   output logic                 sel
);

   lobm_pkg::entry_type entry_ff;
   lobm_pkg::entry_type entry_in;
   logic                eligible;
   logic                price_ok;
   logic                hit;

   assign entry = entry_ff;

   // Does this cell's order qualify for the current search?
   always_comb begin
      price_ok = ctl.search.side ? (entry_ff.price >= ctl.search.limit)
                                 : (entry_ff.price <= ctl.search.limit);
      if (ctl.search.by_id) begin
         eligible = entry_ff.valid && (entry_ff.order_id == ctl.search.order_id);
      end else begin
         eligible = entry_ff.valid && (entry_ff.is_sell != ctl.search.side) &&
                    (entry_ff.trader != ctl.search.trader) && price_ok;
      end
   end

   assign eligible_out = eligible;

   // A cancel hits only the lowest slot among orders with its id; a match hits
   // the first qualifying cell in row order.
   assign hit       = ctl.search.by_id ? (eligible && (entry_ff.slot == win_slot))
                                       : eligible;
   assign sel       = hit && !prev_found;
   assign found_out = hit || prev_found;

   // Cells whose key is not above the new one stay ahead of it.
   assign after_out = entry_ff.valid &&
      (lobm_pkg::sort_key(entry_ff) <= lobm_pkg::sort_key(ctl.new_entry));

   // Next content of the cell.
   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         lobm_pkg::CELL_INSERT: begin
            if (!prev_after) begin
               entry_in = prev_entry;
            end else if (!after_out) begin
               entry_in = ctl.new_entry;
            end
         end
         lobm_pkg::CELL_REMOVE: begin
            if (found_out) begin
               entry_in = next_entry;
            end
         end
         lobm_pkg::CELL_TRIM: begin
            if (sel) begin
               entry_in.quantity = entry_ff.quantity - ctl.trim;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

@@ src/limit_order_book_matcher.sv @@
// Top level of the order book matcher: sequencer, result register and the row of cells.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  operation, ids, side, price, quantity
//   rsp      out        rsp_valid/rsp_ready  kind, ids, tick, quantities, last flag
//
// An item is taken only while no earlier item is in work; after it is accepted, the
// sequencer gives one result per trade and then the closing status, with one search
// over the row of cells per result while the result register is free to take it.
// Reset empties the book at once. A stalled result holds the sequencer in place.
`timescale 1ns / 1ps
module limit_order_book_matcher #(
   parameter int TICK_COUNT     = lobm_pkg::TICK_COUNT_DEF,
   parameter int ORDER_CAPACITY = lobm_pkg::ORDER_CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_order_id,
   input  logic [15:0] req_trader_id,
   input  logic        req_side,
   input  logic [15:0] req_price_tick,
   input  logic [31:0] req_quantity,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_result_kind,
   output logic [31:0] rsp_buy_order_id,
   output logic [31:0] rsp_sell_order_id,
   output logic [9:0]  rsp_trade_tick,
   output logic [31:0] rsp_trade_quantity,
   output logic [31:0] rsp_remaining_quantity,
   output logic        rsp_last_of_run
);

   localparam logic [15:0] TOP_TICK = 16'(TICK_COUNT - 1);
   localparam int SLOT_W = lobm_pkg::SLOT_W;
   localparam int SW     = $clog2(ORDER_CAPACITY);

   lobm_pkg::state_type state_ff, state_in;
   lobm_pkg::op_type    op_ff;
   logic [31:0]         oid_ff;
   logic [15:0]         trader_ff;
   logic                side_ff;
   logic [15:0]         price_ff;
   logic [31:0]         rem_ff, rem_in;

   logic                out_valid_ff;
   lobm_pkg::kind_type  kind_ff, kind_in;
   logic [31:0]         buy_ff, buy_in, sell_ff, sell_in;
   logic [9:0]          tick_ff, tick_in;
   logic [31:0]         tq_ff, tq_in, remout_ff, remout_in;
   logic                last_ff, last_in;
   logic                load;

   lobm_pkg::cell_ctl_type ctl;
   lobm_pkg::entry_type    cell_q [ORDER_CAPACITY];
   logic [ORDER_CAPACITY:0] after_c;
   logic [ORDER_CAPACITY:0] found_c;
   logic [ORDER_CAPACITY-1:0] sel_w;
   logic [ORDER_CAPACITY-1:0] elig_w;
   logic [ORDER_CAPACITY-1:0] id_mask;
   logic [ORDER_CAPACITY-1:0] used_mask;
   logic [SLOT_W-1:0]      win_slot;
   logic [SLOT_W-1:0]      free_slot;
   lobm_pkg::entry_type    pick;
   logic                   room;
   logic                   out_free;
   logic                   price_bad;
   logic [31:0]            tq;

   // Row of cells, kept sorted by side, price and arrival.
   assign after_c[0] = 1'b1;
   assign found_c[0] = 1'b0;
   for (genvar i = 0; i < ORDER_CAPACITY; i++) begin : g_cell
      lobm_pkg::entry_type prev_e, next_e;
      if (i == 0) begin : g_first
         assign prev_e = '0;
      end else begin : g_mid
         assign prev_e = cell_q[i-1];
      end
      if (i == ORDER_CAPACITY - 1) begin : g_last
         assign next_e = '0;
      end else begin : g_rest
         assign next_e = cell_q[i+1];
      end
      lobm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .prev_entry   (prev_e),
         .next_entry   (next_e),
         .prev_after   (after_c[i]),
         .prev_found   (found_c[i]),
         .win_slot     (win_slot),
         .entry        (cell_q[i]),
         .after_out    (after_c[i+1]),
         .found_out    (found_c[i+1]),
         .eligible_out (elig_w[i]),
         .sel          (sel_w[i])
      );
   end

   // Lowest free slot number for an order that rests.
   always_comb begin
      used_mask = '0;
      for (int i = 0; i < ORDER_CAPACITY; i++) begin
         if (cell_q[i].valid) begin
            used_mask[cell_q[i].slot[SW-1:0]] = 1'b1;
         end
      end
      free_slot = '0;
      for (int i = ORDER_CAPACITY - 1; i >= 0; i--) begin
         if (!used_mask[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
   end

   // Lowest slot number among the orders that carry the id to cancel.
   always_comb begin
      id_mask = '0;
      for (int i = 0; i < ORDER_CAPACITY; i++) begin
         if (elig_w[i]) begin
            id_mask[cell_q[i].slot[SW-1:0]] = 1'b1;
         end
      end
      win_slot = '0;
      for (int i = ORDER_CAPACITY - 1; i >= 0; i--) begin
         if (id_mask[i]) begin
            win_slot = SLOT_W'(i);
         end
      end
   end

   // Selected order; at most one cell is selected.
   always_comb begin
      pick = '0;
      for (int i = 0; i < ORDER_CAPACITY; i++) begin
         if (sel_w[i]) begin
            pick = lobm_pkg::entry_type'(pick | cell_q[i]);
         end
      end
   end

   // Cells stay packed at the front, so the book is full when the last one is in use.
   assign room      = !cell_q[ORDER_CAPACITY-1].valid;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign price_bad = ({16'd0, price_ff} >= 32'(TICK_COUNT));
   assign tq        = (rem_ff < pick.quantity) ? rem_ff : pick.quantity;
   assign req_ready = (state_ff == lobm_pkg::ST_IDLE);

   // Search criteria and the order that would rest.
   always_comb begin
      ctl = '0;
      ctl.search.by_id    = (op_ff == lobm_pkg::OP_CANCEL);
      ctl.search.order_id = oid_ff;
      ctl.search.side     = side_ff;
      ctl.search.trader   = trader_ff;
      if (op_ff == lobm_pkg::OP_LIMIT) begin
         ctl.search.limit = price_ff;
      end else begin
         ctl.search.limit = side_ff ? 16'd0 : TOP_TICK;
      end
      ctl.new_entry.valid    = 1'b1;
      ctl.new_entry.order_id = oid_ff;
      ctl.new_entry.trader   = trader_ff;
      ctl.new_entry.is_sell  = side_ff;
      ctl.new_entry.price    = price_ff;
      ctl.new_entry.quantity = rem_ff;
      ctl.new_entry.slot     = free_slot;
      ctl.trim               = tq;
      ctl.op                 = lobm_pkg::CELL_HOLD;

      state_in  = state_ff;
      rem_in    = rem_ff;
      load      = 1'b0;
      kind_in   = lobm_pkg::RK_DONE;
      buy_in    = oid_ff;
      sell_in   = 32'd0;
      tick_in   = 10'd0;
      tq_in     = 32'd0;
      remout_in = rem_ff;
      last_in   = 1'b1;

      unique case (state_ff)
         lobm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lobm_pkg::ST_WORK;
               rem_in   = req_quantity;
            end
         end
         lobm_pkg::ST_WORK: begin
            if (out_free) begin
               load = 1'b1;
               if (op_ff == lobm_pkg::OP_CANCEL) begin
                  state_in = lobm_pkg::ST_IDLE;
                  if (found_c[ORDER_CAPACITY]) begin
                     ctl.op    = lobm_pkg::CELL_REMOVE;
                     kind_in   = lobm_pkg::RK_CANCELLED;
                     remout_in = pick.quantity;
                  end else begin
                     kind_in   = lobm_pkg::RK_NOT_FOUND;
                     remout_in = 32'd0;
                  end
               end else if (op_ff == lobm_pkg::OP_UNUSED ||
                            (op_ff == lobm_pkg::OP_LIMIT && price_bad)) begin
                  state_in = lobm_pkg::ST_IDLE;
                  kind_in  = lobm_pkg::RK_REJECTED;
               end else if (rem_ff != 32'd0 && found_c[ORDER_CAPACITY]) begin
                  // One fill against the best, oldest eligible order.
                  ctl.op    = (pick.quantity == tq) ? lobm_pkg::CELL_REMOVE
                                                    : lobm_pkg::CELL_TRIM;
                  rem_in    = rem_ff - tq;
                  kind_in   = lobm_pkg::RK_TRADE;
                  buy_in    = side_ff ? pick.order_id : oid_ff;
                  sell_in   = side_ff ? oid_ff : pick.order_id;
                  tick_in   = pick.price[lobm_pkg::TICK_W-1:0];
                  tq_in     = tq;
                  remout_in = rem_ff - tq;
                  last_in   = 1'b0;
               end else begin
                  // Closing status: rest a limit leftover or report it.
                  state_in = lobm_pkg::ST_IDLE;
                  if (op_ff == lobm_pkg::OP_LIMIT && rem_ff != 32'd0) begin
                     if (room) begin
                        ctl.op  = lobm_pkg::CELL_INSERT;
                        kind_in = lobm_pkg::RK_RESTED;
                     end else begin
                        kind_in = lobm_pkg::RK_FULL;
                     end
                  end else begin
                     kind_in = lobm_pkg::RK_DONE;
                  end
               end
            end
         end
         default: begin
            state_in = lobm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lobm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Latched item fields.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (state_ff == lobm_pkg::ST_IDLE && req_valid) begin
         op_ff     <= lobm_pkg::op_type'(req_operation);
         oid_ff    <= req_order_id;
         trader_ff <= req_trader_id;
         side_ff   <= req_side;
         price_ff  <= req_price_tick;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_in;
         buy_ff    <= buy_in;
         sell_ff   <= sell_in;
         tick_ff   <= tick_in;
         tq_ff     <= tq_in;
         remout_ff <= remout_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_result_kind        = kind_ff;
   assign rsp_buy_order_id       = buy_ff;
   assign rsp_sell_order_id      = sell_ff;
   assign rsp_trade_tick         = tick_ff;
   assign rsp_trade_quantity     = tq_ff;
   assign rsp_remaining_quantity = remout_ff;
   assign rsp_last_of_run        = last_ff;

endmodule

@@ src/lobm_checker.sv @@
// Port checker of the order book matcher and its bind to the top level.
`timescale 1ns / 1ps
module lobm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_result_kind,
   input logic [31:0] rsp_sell_order_id,
   input logic        rsp_last_of_run
);

   // A result held back keeps its kind.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind))
      else $error("stalled result changed");

   // After an item is taken, no new item is taken in the next cycle.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while one is in work");

   // Trades never close a run.
   a_trade_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == lobm_pkg::RK_TRADE |-> !rsp_last_of_run)
      else $error("trade marked last");

   // Every status result closes its run and names no seller.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != lobm_pkg::RK_TRADE |->
         rsp_last_of_run && rsp_sell_order_id == 32'd0)
      else $error("status result malformed");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_result_kind   (rsp_result_kind),
   .rsp_sell_order_id (rsp_sell_order_id),
   .rsp_last_of_run   (rsp_last_of_run)
);
